@@ hdl/utf8_byte_stream_decoder_macros.svh @@
// Assertion macros shared by the UTF-8 decoder RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every decoder module.
package u8d_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CP_W        = 21;
	localparam int unsigned M_TDATA_W   = 24;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// One decoded request: rep_cnt replacement results, then an optional final result
	typedef struct packed {
		logic [1:0]      rep_cnt;
		logic            has_final;
		logic [CP_W-1:0] final_cp;
		logic            text_end;
	} u8d_cmd_t;

	// Queue fill status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} u8d_qstat_t;

endpackage

@@ hdl/u8d_front.sv @@
// UTF-8 decoder front end (uses u8d_pkg): accepts bytes, tracks the held
// sequence, and makes a back-end request of each byte that yields results.
module u8d_front import u8d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic              text_end,
	input  u8d_qstat_t        qstat,
	output logic              in_ready,
	output logic              push,
	output u8d_cmd_t          cmd
);

	logic [CP_W-1:0] partial_q;
	logic [1:0]      needed_q;
	logic [1:0]      held_q;

	logic [CP_W-1:0] partial_d;
	logic [1:0]      needed_d;
	logic [1:0]      held_d;
	logic [CP_W-1:0] shifted;
	logic [1:0]      held_inc;
	logic            is_cont;
	logic            is_lead2;
	logic            is_lead3;
	logic            is_lead4;
	logic            accept;

	// Take a byte whenever the queue has room
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Classify the byte
	assign is_cont  = (byte_in[7:6] == 2'b10);
	assign is_lead2 = (byte_in[7:5] == 3'b110);
	assign is_lead3 = (byte_in[7:4] == 4'b1110);
	assign is_lead4 = (byte_in[7:3] == 5'b11110);
	assign shifted  = {partial_q[CP_W-7:0], byte_in[5:0]};
	assign held_inc = held_q + 2'd1;

	// Decode the byte against the held sequence
	always_comb begin
		partial_d     = partial_q;
		needed_d      = needed_q;
		held_d        = held_q;
		cmd.rep_cnt   = 2'd0;
		cmd.has_final = 1'b0;
		cmd.final_cp  = REPLACEMENT_CP;
		cmd.text_end  = text_end;
		if (needed_q != 2'd0 && is_cont) begin
			if (held_inc == needed_q) begin
				cmd.has_final = 1'b1;
				cmd.final_cp  = shifted;
				partial_d     = '0;
				needed_d      = 2'd0;
				held_d        = 2'd0;
			end else if (text_end) begin
				// lead and all held continuations become replacements
				cmd.rep_cnt   = held_inc;
				cmd.has_final = 1'b1;
			end else begin
				partial_d = shifted;
				held_d    = held_inc;
			end
		end else begin
			// flush a broken sequence, then decode the byte afresh
			if (needed_q != 2'd0) begin
				cmd.rep_cnt = held_inc;
				partial_d   = '0;
				needed_d    = 2'd0;
				held_d      = 2'd0;
			end
			if (!byte_in[7]) begin
				cmd.has_final = 1'b1;
				cmd.final_cp  = {{(CP_W-BYTE_W){1'b0}}, byte_in};
			end else if (is_lead2 || is_lead3 || is_lead4) begin
				if (text_end) begin
					cmd.has_final = 1'b1;
				end else if (is_lead2) begin
					partial_d = {{(CP_W-5){1'b0}}, byte_in[4:0]};
					needed_d  = 2'd1;
				end else if (is_lead3) begin
					partial_d = {{(CP_W-4){1'b0}}, byte_in[3:0]};
					needed_d  = 2'd2;
				end else begin
					partial_d = {{(CP_W-3){1'b0}}, byte_in[2:0]};
					needed_d  = 2'd3;
				end
			end else begin
				cmd.has_final = 1'b1;
			end
		end
		// end of text always returns to the idle state
		if (text_end) begin
			partial_d = '0;
			needed_d  = 2'd0;
			held_d    = 2'd0;
		end
	end

	// Queue a request only when the byte yields results
	assign push = accept && (cmd.rep_cnt != 2'd0 || cmd.has_final);

	// Hold the sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			needed_q  <= 2'd0;
			held_q    <= 2'd0;
		end else if (accept) begin
			partial_q <= partial_d;
			needed_q  <= needed_d;
			held_q    <= held_d;
		end
	end

endmodule

@@ hdl/u8d_queue.sv @@
// Request queue between the decoder front and back ends.
// Register-based circular buffer of u8d_cmd_t; uses u8d_pkg.
module u8d_queue import u8d_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  u8d_cmd_t   din,
	input  logic       pop,
	output u8d_cmd_t   dout,
	output u8d_qstat_t qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u8d_cmd_t         slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign dout        = slots_q[rd_ptr_q];
	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);

	// Store incoming requests
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/u8d_back.sv @@
// UTF-8 decoder back end (uses u8d_pkg): expands each queued request
// as result items, one per cycle unless stalled, to a registered output.
module u8d_back import u8d_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8d_cmd_t             head,
	input  u8d_qstat_t           qstat,
	output logic                 pop,
	output logic                 load,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	logic [1:0]      idx_q;
	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            last_q;
	logic            done_q;

	logic            item_end;
	logic [CP_W-1:0] item_cp;

	// Load the output stage when it is empty or being drained
	assign load = !qstat.empty && (!valid_q || m_tready);

	// Pick the current item of the head request
	assign item_end = ({1'b0, idx_q} + 3'd1) == ({1'b0, head.rep_cnt} + {2'b0, head.has_final});
	assign item_cp  = (idx_q < head.rep_cnt) ? REPLACEMENT_CP : head.final_cp;
	assign pop      = load && item_end;

	// Step through the items of a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= item_end ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= item_cp;
			last_q <= item_end;
			done_q <= item_end && head.text_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W-CP_W){1'b0}}, cp_q};
	assign m_tlast  = last_q;
	assign m_tuser  = done_q;

endmodule

@@ hdl/utf8_byte_stream_decoder.sv @@
// A byte's first result passes through the request queue, then the output register.
// Throughput: one byte per cycle while the request queue has room; a byte that
// yields several results has them emitted one at a time, the request queue absorbing it.
// The output register accepts a new result whenever the current one is taken.
// Reset (arst_n low, asynchronous) clears the held sequence, the queue and the output.
`include "utf8_byte_stream_decoder_macros.svh"

module utf8_byte_stream_decoder import u8d_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] byte_in
	input  logic                 s_tlast,   // text_end
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser    // [0] text_done
);

	u8d_cmd_t   push_cmd;
	u8d_cmd_t   head_cmd;
	u8d_qstat_t qstat;
	logic       push;
	logic       pop;
	logic       load;

	// Classify incoming bytes
	u8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.byte_in  (s_tdata),
		.text_end (s_tlast),
		.qstat    (qstat),
		.in_ready (s_tready),
		.push     (push),
		.cmd      (push_cmd)
	);

	// Decouple front and back
	u8d_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head_cmd),
		.qstat  (qstat)
	);

	// Emit results
	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_cmd),
		.qstat    (qstat),
		.pop      (pop),
		.load     (load),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`U8D_ASSERT_NOW(a_done_ends_run, m_tvalid && m_tuser, m_tlast, "text_done without run_last")
	`U8D_ASSERT_NOW(a_no_push_full, push, !qstat.full, "request pushed into full queue")
	`U8D_ASSERT_NOW(a_pop_on_load, pop, load && !qstat.empty, "request popped without load")
	`U8D_ASSERT_NEXT(a_load_shows, load, m_tvalid, "loaded result not presented")

endmodule
